>>> rtl/dc_pkg.sv
// divisor count package: widths, microcode encodings and the control store
package dc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = 32;
  localparam int CNT_W       = 11;
  localparam int E_W         = $clog2(VALUE_WIDTH + 2);
  localparam int DC_W        = $clog2(VALUE_WIDTH + 1);
  localparam int UPC_W       = 5;
  localparam int UCODE_LEN   = 19;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE,
    OP_MUL_E,
    OP_SET_D3,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_TAKE_Q,
    OP_INC_E,
    OP_ADD_D2,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_M_ZERO,
    C_M_EVEN,
    C_DIV_MORE,
    C_E_NZ,
    C_D_GT_Q,
    C_R_NZ,
    C_M_LE1,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic start;
    logic m_zero;
    logic m_even;
    logic div_more;
    logic e_nz;
    logic d_gt_q;
    logic r_nz;
    logic m_le1;
    logic out_busy;
  } dp_status_t;

  localparam logic [UPC_W-1:0] A_IDLE      = 5'd0;
  localparam logic [UPC_W-1:0] A_ZCHK      = 5'd1;
  localparam logic [UPC_W-1:0] A_HALVE     = 5'd2;
  localparam logic [UPC_W-1:0] A_MUL_TWO   = 5'd3;
  localparam logic [UPC_W-1:0] A_SET_D3    = 5'd4;
  localparam logic [UPC_W-1:0] A_DIV_START = 5'd5;
  localparam logic [UPC_W-1:0] A_DIV_STEP  = 5'd6;
  localparam logic [UPC_W-1:0] A_CHK_INNER = 5'd7;
  localparam logic [UPC_W-1:0] A_CHK_BOUND = 5'd8;
  localparam logic [UPC_W-1:0] A_CHK_OUTER = 5'd9;
  localparam logic [UPC_W-1:0] A_CHK_REM   = 5'd10;
  localparam logic [UPC_W-1:0] A_TAKE_Q    = 5'd11;
  localparam logic [UPC_W-1:0] A_MUL_PRIME = 5'd12;
  localparam logic [UPC_W-1:0] A_NEXT_D    = 5'd13;
  localparam logic [UPC_W-1:0] A_CHK_REST  = 5'd14;
  localparam logic [UPC_W-1:0] A_REST_INC  = 5'd15;
  localparam logic [UPC_W-1:0] A_REST_MUL  = 5'd16;
  localparam logic [UPC_W-1:0] A_OUT       = 5'd17;
  localparam logic [UPC_W-1:0] A_RETURN    = 5'd18;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, tgt: A_IDLE};
    unique case (addr)
      A_IDLE:      w = '{op: OP_LOAD,      cond: C_NOT_START, tgt: A_IDLE};
      A_ZCHK:      w = '{op: OP_NOP,       cond: C_M_ZERO,    tgt: A_OUT};
      A_HALVE:     w = '{op: OP_HALVE,     cond: C_M_EVEN,    tgt: A_HALVE};
      A_MUL_TWO:   w = '{op: OP_MUL_E,     cond: C_NEVER,     tgt: A_IDLE};
      A_SET_D3:    w = '{op: OP_SET_D3,    cond: C_NEVER,     tgt: A_IDLE};
      A_DIV_START: w = '{op: OP_DIV_START, cond: C_NEVER,     tgt: A_IDLE};
      A_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  tgt: A_DIV_STEP};
      A_CHK_INNER: w = '{op: OP_NOP,       cond: C_E_NZ,      tgt: A_CHK_REM};
      A_CHK_BOUND: w = '{op: OP_NOP,       cond: C_D_GT_Q,    tgt: A_CHK_REST};
      A_CHK_OUTER: w = '{op: OP_NOP,       cond: C_R_NZ,      tgt: A_NEXT_D};
      A_CHK_REM:   w = '{op: OP_NOP,       cond: C_R_NZ,      tgt: A_MUL_PRIME};
      A_TAKE_Q:    w = '{op: OP_TAKE_Q,    cond: C_ALWAYS,    tgt: A_DIV_START};
      A_MUL_PRIME: w = '{op: OP_MUL_E,     cond: C_NEVER,     tgt: A_IDLE};
      A_NEXT_D:    w = '{op: OP_ADD_D2,    cond: C_ALWAYS,    tgt: A_DIV_START};
      A_CHK_REST:  w = '{op: OP_NOP,       cond: C_M_LE1,     tgt: A_OUT};
      A_REST_INC:  w = '{op: OP_INC_E,     cond: C_NEVER,     tgt: A_IDLE};
      A_REST_MUL:  w = '{op: OP_MUL_E,     cond: C_NEVER,     tgt: A_IDLE};
      A_OUT:       w = '{op: OP_OUT,       cond: C_OUT_BUSY,  tgt: A_OUT};
      A_RETURN:    w = '{op: OP_NOP,       cond: C_ALWAYS,    tgt: A_IDLE};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,    tgt: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/divisor_count_core.sv
// divisor count top level: microsequencer and datapath
// Counts the positive divisors of the low VALUE_WIDTH bits of in_n_value by trial
// division: factors of two are stripped one per cycle, then odd candidates 3, 5, 7, ...
// are tried while the candidate does not exceed the quotient. Each trial goes through
// one shift-subtract divider that retires one quotient bit per cycle; a prime cofactor
// near 2^32 takes roughly 32768 candidates, while small or smooth inputs need far fewer.
// One item is worked on at a time; after the result is loaded into the output register
// the program passes through A_RETURN back to A_IDLE and takes the next item, even while
// that result still waits to be read. Zero gives count 0 with out_invalid set.
module divisor_count_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [dc_pkg::IN_W-1:0]  in_n_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [dc_pkg::CNT_W-1:0] out_divisor_count,
  output logic                     out_invalid
);
  import dc_pkg::*;

  uword_t     uw;
  dp_status_t status;

  dc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .uw       (uw),
    .in_ready (in_ready)
  );

  dc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .uw                (uw),
    .in_valid          (in_valid),
    .in_n_value        (in_n_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_divisor_count (out_divisor_count),
    .out_invalid       (out_invalid),
    .status            (status)
  );

endmodule

>>> rtl/dc_seq.sv
// divisor count microsequencer: step counter, control store and jump logic
module dc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  dc_pkg::dp_status_t status,
  output dc_pkg::uword_t     uw,
  output logic               in_ready
);
  import dc_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             take;

  assign uw       = ucode(upc_r);
  assign in_ready = (upc_r == A_IDLE);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_START: take = !status.start;
      C_M_ZERO:    take = status.m_zero;
      C_M_EVEN:    take = status.m_even;
      C_DIV_MORE:  take = status.div_more;
      C_E_NZ:      take = status.e_nz;
      C_D_GT_Q:    take = status.d_gt_q;
      C_R_NZ:      take = status.r_nz;
      C_M_LE1:     take = status.m_le1;
      C_OUT_BUSY:  take = status.out_busy;
      default:     take = 1'b1;
    endcase
    upc_nxt = take ? uw.tgt : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= A_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r < UPC_W'(UCODE_LEN))
    else $error("step counter left the control store");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == A_IDLE) && status.start |=> upc_r == A_ZCHK)
    else $error("accepted item did not start the program");

endmodule

>>> rtl/dc_dpath.sv
// divisor count datapath: cofactor, candidate, shift-subtract divider, count product
module dc_dpath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dc_pkg::uword_t          uw,
  input  logic                    in_valid,
  input  logic [dc_pkg::IN_W-1:0] in_n_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [dc_pkg::CNT_W-1:0] out_divisor_count,
  output logic                    out_invalid,
  output dc_pkg::dp_status_t      status
);
  import dc_pkg::*;

  logic [VALUE_WIDTH-1:0] m_r, m_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [VALUE_WIDTH-1:0] dq_r, dq_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [DC_W-1:0]        cnt_r, cnt_nxt;
  logic [E_W-1:0]         e_r, e_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic                   zero_r, zero_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]       out_count_r, out_count_nxt;
  logic                   out_invalid_r, out_invalid_nxt;

  logic [VALUE_WIDTH:0]   trial;
  logic [CNT_W+E_W-1:0]   prod;
  logic [E_W-1:0]         e_inc;

  assign e_inc = e_r + E_W'(1);
  assign prod  = (CNT_W+E_W)'(total_r) * (CNT_W+E_W)'(e_inc);
  assign trial = {rem_r, dq_r[VALUE_WIDTH-1]} - {1'b0, d_r};

  always_comb begin
    m_nxt           = m_r;
    d_nxt           = d_r;
    dq_nxt          = dq_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    e_nxt           = e_r;
    total_nxt       = total_r;
    zero_nxt        = zero_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_count_nxt   = out_count_r;
    out_invalid_nxt = out_invalid_r;
    unique case (uw.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_valid) begin
          m_nxt     = VALUE_WIDTH'(in_n_value);
          e_nxt     = '0;
          total_nxt = CNT_W'(1);
          zero_nxt  = (VALUE_WIDTH'(in_n_value) == '0);
        end
      end
      OP_HALVE: begin
        if (!m_r[0]) begin
          m_nxt = m_r >> 1;
          e_nxt = e_inc;
        end
      end
      OP_MUL_E: begin
        total_nxt = (prod > (CNT_W+E_W)'(COUNT_MAX)) ? COUNT_MAX : prod[CNT_W-1:0];
        e_nxt     = '0;
      end
      OP_SET_D3: begin
        d_nxt = VALUE_WIDTH'(3);
      end
      OP_DIV_START: begin
        dq_nxt  = m_r;
        rem_nxt = '0;
        cnt_nxt = DC_W'(VALUE_WIDTH);
      end
      OP_DIV_STEP: begin
        if (!trial[VALUE_WIDTH]) begin
          rem_nxt = trial[VALUE_WIDTH-1:0];
          dq_nxt  = {dq_r[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[VALUE_WIDTH-2:0], dq_r[VALUE_WIDTH-1]};
          dq_nxt  = {dq_r[VALUE_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DC_W'(1);
      end
      OP_TAKE_Q: begin
        m_nxt = dq_r;
        e_nxt = e_inc;
      end
      OP_INC_E: begin
        e_nxt = e_inc;
      end
      OP_ADD_D2: begin
        d_nxt = d_r + VALUE_WIDTH'(2);
      end
      OP_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt   = 1'b1;
          out_count_nxt   = zero_r ? '0 : total_r;
          out_invalid_nxt = zero_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r           <= m_nxt;
    d_r           <= d_nxt;
    dq_r          <= dq_nxt;
    rem_r         <= rem_nxt;
    cnt_r         <= cnt_nxt;
    e_r           <= e_nxt;
    total_r       <= total_nxt;
    zero_r        <= zero_nxt;
    out_count_r   <= out_count_nxt;
    out_invalid_r <= out_invalid_nxt;
  end

  assign status.start    = in_valid;
  assign status.m_zero   = (m_r == '0);
  assign status.m_even   = !m_r[0];
  assign status.div_more = (cnt_r > DC_W'(1));
  assign status.e_nz     = (e_r != '0);
  assign status.d_gt_q   = (d_r > dq_r);
  assign status.r_nz     = (rem_r != '0);
  assign status.m_le1    = (m_r <= VALUE_WIDTH'(1));
  assign status.out_busy = out_valid_r;

  assign out_valid         = out_valid_r;
  assign out_divisor_count = out_count_r;
  assign out_invalid       = out_invalid_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    uw.op == OP_DIV_START |=> cnt_r == DC_W'(VALUE_WIDTH))
    else $error("divider did not load its step count");

  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    uw.op == OP_DIV_STEP |-> (rem_r < d_r) && d_r[0])
    else $error("partial remainder or candidate out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_invalid_r |-> out_count_r == '0)
    else $error("invalid result carries a nonzero count");

endmodule
